// ===== sv/gsa_pkg.sv =====
// Shared constants and types for the generational slot allocator.
`default_nettype none

package gsa_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int DATA_W = 32;

    localparam logic [DATA_W-1:0] NO_LOC = '1;

    localparam logic [2:0] OP_ALLOC    = 3'd0;
    localparam logic [2:0] OP_FREE     = 3'd1;
    localparam logic [2:0] OP_GET      = 3'd2;
    localparam logic [2:0] OP_SET      = 3'd3;
    localparam logic [2:0] OP_CONTAINS = 3'd4;
    localparam logic [2:0] OP_BUMP     = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] gen;
        logic [DATA_W-1:0] arch;
        logic [DATA_W-1:0] word;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/generational_slot_allocator.sv =====
// Generational slot allocator: slot tables and free stack in synchronous memories.
`default_nettype none

// Hands out slot indices tagged with a 32-bit generation so stale handles can
// be caught. Operations: alloc (pop the most recently freed slot, or append a
// fresh slot with generation 0 and an invalid location, or report full),
// free, get, set location, contains, bump generation and clear. All state
// lives in four single-port-style memories (generation, archetype, location
// word, free stack) with registered reads; the flops are the sequencer state,
// the two counters (slots in use, free stack depth), the valid flag and the
// item, read data and result registers. Items are read from memory at the
// edge they are accepted and written back when they commit. An alloc that
// reuses a freed slot commits from a pop state, since the generation read
// depends on the stack entry just read. One item is in flight at a time. The
// result register lets a new item be accepted while the previous result still
// waits; an item completes (and commits its memory writes) only once the result
// register is free, so a stalled output holds the block in its final step.
// Memory contents need no clearing after reset: every read that matters is of
// an entry below the in-use or free-stack count, written first.
module generational_slot_allocator
(
    input  wire                         clk,
    input  wire                         rst_n,

    input  wire                         req_valid,
    output logic                        req_ready,
    input  wire  [2:0]                  operation,
    input  wire  [gsa_pkg::IDX_W-1:0]   slot_index,
    input  wire  [gsa_pkg::DATA_W-1:0]  generation,
    input  wire  [gsa_pkg::DATA_W-1:0]  archetype,
    input  wire  [gsa_pkg::DATA_W-1:0]  location_word,
    input  wire  [gsa_pkg::DATA_W-1:0]  generation_bump,

    output logic                        rsp_valid,
    input  wire                         rsp_ready,
    output logic [1:0]                  status,
    output logic [gsa_pkg::IDX_W-1:0]   slot_index_res,
    output logic [gsa_pkg::DATA_W-1:0]  generation_out,
    output logic [gsa_pkg::DATA_W-1:0]  archetype_out,
    output logic [gsa_pkg::DATA_W-1:0]  location_word_out
);
    import gsa_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for an item
    localparam logic [1:0] S_EXEC = 2'd1;   // read data valid, commit
    localparam logic [1:0] S_POP  = 2'd2;   // popped slot's generation valid

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // memories
    logic [DATA_W-1:0] gen_mem  [SLOTS];
    logic [DATA_W-1:0] arch_mem [SLOTS];
    logic [DATA_W-1:0] word_mem [SLOTS];
    logic [IDX_W-1:0]  stk_mem  [SLOTS];

    // control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] fcnt_reg, fcnt_next;
    logic             out_valid_reg;

    // item registers
    logic [2:0]        op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] gen_reg;
    logic [DATA_W-1:0] arch_reg;
    logic [DATA_W-1:0] word_reg;
    logic [DATA_W-1:0] bump_reg;

    // registered read data
    logic [DATA_W-1:0] gen_rd;
    logic [DATA_W-1:0] arch_rd;
    logic [DATA_W-1:0] word_rd;
    logic [IDX_W-1:0]  stk_rd;

    // result register
    res_t res_reg;
    res_t res_next;

    logic              accept;
    logic              out_free;
    logic              pop;
    logic              finish;
    logic              in_range;
    logic              gen_match;
    logic              gen_re;
    logic [IDX_W-1:0]  gen_raddr;
    logic [IDX_W-1:0]  stk_raddr;
    logic              gen_we;
    logic              loc_we;
    logic              stk_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] gen_wd;
    logic [DATA_W-1:0] arch_wd;
    logic [DATA_W-1:0] word_wd;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;

    assign in_range  = {1'b0, idx_reg} < used_reg;
    assign gen_match = (gen_rd == gen_reg);

    // alloc with a non-empty free stack needs a second read
    assign pop    = (state_reg == S_EXEC) && (op_reg == OP_ALLOC) && (fcnt_reg != '0);
    assign finish = out_free && (((state_reg == S_EXEC) && !pop) || (state_reg == S_POP));

    // generation read: at accept by the item's index, else by the popped slot
    assign gen_re    = accept || pop;
    assign gen_raddr = (state_reg == S_IDLE) ? slot_index : stk_rd;
    assign stk_raddr = fcnt_reg[IDX_W-1:0] - IDX_W'(1);

    always_comb
    begin
        res_next  = '{status: ST_MISS, slot: '0, gen: '0, arch: '0, word: '0};
        gen_we    = 1'b0;
        loc_we    = 1'b0;
        stk_we    = 1'b0;
        wr_addr   = idx_reg;
        gen_wd    = gen_reg + DATA_W'(1);
        arch_wd   = NO_LOC;
        word_wd   = NO_LOC;
        used_next = used_reg;
        fcnt_next = fcnt_reg;

        if (state_reg == S_POP)
        begin
            res_next.status = ST_OK;
            res_next.slot   = stk_rd;
            res_next.gen    = gen_rd;
            fcnt_next       = fcnt_reg - ONE_C;
        end
        else
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (used_reg < SLOTS_C)
                    begin
                        wr_addr         = used_reg[IDX_W-1:0];
                        gen_we          = 1'b1;
                        gen_wd          = '0;
                        loc_we          = 1'b1;
                        used_next       = used_reg + ONE_C;
                        res_next.status = ST_OK;
                        res_next.slot   = used_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        res_next.status = ST_FULL;
                    end
                end
                OP_FREE:
                begin
                    if (in_range && gen_match)
                    begin
                        gen_we          = 1'b1;
                        loc_we          = 1'b1;
                        res_next.status = ST_OK;
                        res_next.arch   = arch_rd;
                        res_next.word   = word_rd;
                        // push dropped when the stack is already full
                        if (fcnt_reg < SLOTS_C)
                        begin
                            stk_we    = 1'b1;
                            fcnt_next = fcnt_reg + ONE_C;
                        end
                    end
                end
                OP_GET:
                begin
                    if (in_range && gen_match && (arch_rd != NO_LOC))
                    begin
                        res_next.status = ST_OK;
                        res_next.arch   = arch_rd;
                        res_next.word   = word_rd;
                    end
                end
                OP_SET:
                begin
                    if (in_range)
                    begin
                        loc_we          = 1'b1;
                        arch_wd         = arch_reg;
                        word_wd         = word_reg;
                        res_next.status = ST_OK;
                    end
                end
                OP_CONTAINS:
                begin
                    if (in_range && gen_match)
                    begin
                        res_next.status = ST_OK;
                    end
                end
                OP_BUMP:
                begin
                    // only slots without a live location may be bumped
                    if (in_range && (arch_rd == NO_LOC))
                    begin
                        gen_we          = 1'b1;
                        gen_wd          = gen_rd + bump_reg;
                        res_next.status = ST_OK;
                    end
                end
                OP_CLEAR:
                begin
                    used_next       = '0;
                    fcnt_next       = '0;
                    res_next.status = ST_OK;
                end
                default:
                begin
                    res_next.status = ST_MISS;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (pop)
                begin
                    state_next = S_POP;
                end
                else if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                used_reg      <= used_next;
                fcnt_reg      <= fcnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= operation;
            idx_reg  <= slot_index;
            gen_reg  <= generation;
            arch_reg <= archetype;
            word_reg <= location_word;
            bump_reg <= generation_bump;
        end
        if (finish)
        begin
            res_reg <= res_next;
        end
    end

    // memories: registered reads, writes on commit
    always_ff @(posedge clk)
    begin
        if (gen_re)
        begin
            gen_rd <= gen_mem[gen_raddr];
        end
        if (finish && gen_we)
        begin
            gen_mem[wr_addr] <= gen_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arch_rd <= arch_mem[slot_index];
            word_rd <= word_mem[slot_index];
        end
        if (finish && loc_we)
        begin
            arch_mem[wr_addr] <= arch_wd;
            word_mem[wr_addr] <= word_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stk_rd <= stk_mem[stk_raddr];
        end
        if (finish && stk_we)
        begin
            stk_mem[fcnt_reg[IDX_W-1:0]] <= idx_reg;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign status            = res_reg.status;
    assign slot_index_res    = res_reg.slot;
    assign generation_out    = res_reg.gen;
    assign archetype_out     = res_reg.arch;
    assign location_word_out = res_reg.word;

    // checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SLOTS_C)
        else $error("slots in use beyond capacity");

    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= SLOTS_C)
        else $error("free stack depth beyond capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execute");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("commit did not load the result register");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (fcnt_reg != '0))
        else $error("pop from an empty free stack");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (res_next.status == ST_OK || res_next.status == ST_MISS
                    || res_next.status == ST_FULL))
        else $error("undefined status code");

endmodule

`default_nettype wire
